// ===== hw/rtl/rtmm_pkg.sv =====
package rtmm_pkg;

  // Matrix size limits
  localparam int MAX_DIM = 16;
  localparam int DIM_LIM = (MAX_DIM < 16) ? MAX_DIM : 16;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int COL_W   = $clog2(DIM_LIM);
  localparam int CNT_W   = $clog2(DIM_LIM + 1);
  localparam int B_AW    = 2 * IDX_W;
  localparam int B_DEPTH = 2 ** B_AW;

  // Field widths
  localparam int VAL_W = 16;
  localparam int ACC_W = 40;
  localparam int PRD_W = 32;
  localparam int TAG_W = 8;
  localparam int REG_W = 5;

  // Command queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_INNER_DIM = 1'b0;
  localparam logic REG_OUT_COLS  = 1'b1;

  // Operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_ROW  = 1'b1;

  // Effective dimensions
  typedef struct packed {
    logic [CNT_W-1:0] kdim;
    logic [CNT_W-1:0] ncol;
  } rtmm_cfg_t;

  // Classified command between front and back
  typedef struct packed {
    logic                    is_load;
    logic [B_AW-1:0]         waddr;
    logic signed [VAL_W-1:0] value;
    logic [TAG_W-1:0]        tag;
    logic                    row_end;
    logic                    mac_en;
    logic [COL_W-1:0]        k;
    logic [CNT_W-1:0]        ncol;
  } rtmm_cmd_t;

  // Clamp a register value to [1, DIM_LIM]
  function automatic logic [CNT_W-1:0] clamp_dim(input logic [REG_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (int'(v) > DIM_LIM) begin
      r = CNT_W'(DIM_LIM);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/rtmm_if.sv =====
interface rtmm_in_if;
  logic                            valid;
  logic                            ready;
  logic                            operation;
  logic [3:0]                      b_row;
  logic [3:0]                      b_col;
  logic signed [rtmm_pkg::VAL_W-1:0] value;
  logic [rtmm_pkg::TAG_W-1:0]      row_tag;
  logic                            row_end;

  modport source (output valid, operation, b_row, b_col, value, row_tag, row_end,
                  input ready);
  modport sink (input valid, operation, b_row, b_col, value, row_tag, row_end,
                output ready);
endinterface

interface rtmm_out_if;
  logic                            valid;
  logic                            ready;
  logic [3:0]                      out_col;
  logic signed [rtmm_pkg::ACC_W-1:0] out_value;
  logic [rtmm_pkg::TAG_W-1:0]      out_row_tag;
  logic                            last_of_row;

  modport source (output valid, out_col, out_value, out_row_tag, last_of_row,
                  input ready);
  modport sink (input valid, out_col, out_value, out_row_tag, last_of_row,
                output ready);
endinterface

// ===== hw/rtl/rtmm_ram.sv =====
module rtmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/rtmm_front.sv =====
module rtmm_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  rtmm_in_if.sink             in_i,
  input  rtmm_pkg::rtmm_cfg_t cfg_i,
  input  logic                q_full_i,
  output logic                push_o,
  output rtmm_pkg::rtmm_cmd_t cmd_o
);

  logic [rtmm_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                       accept;
  logic                       in_range;
  logic                       mac_en;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;

  // Classify the transaction
  assign in_range = (int'(in_i.b_row) < rtmm_pkg::DIM_LIM) &&
                    (int'(in_i.b_col) < rtmm_pkg::DIM_LIM);
  assign mac_en   = cnt_q < cfg_i.kdim;

  always_comb begin
    cmd_o.is_load = (in_i.operation == rtmm_pkg::OP_LOAD);
    cmd_o.waddr   = {rtmm_pkg::IDX_W'(in_i.b_row), rtmm_pkg::IDX_W'(in_i.b_col)};
    cmd_o.value   = in_i.value;
    cmd_o.tag     = in_i.row_tag;
    cmd_o.row_end = in_i.row_end;
    cmd_o.mac_en  = mac_en;
    cmd_o.k       = cnt_q[rtmm_pkg::COL_W-1:0];
    cmd_o.ncol    = cfg_i.ncol;
  end

  // Drop loads outside the store
  assign push_o = accept && ((in_i.operation == rtmm_pkg::OP_ROW) || in_range);

  // Track the element index of the current row
  always_comb begin
    cnt_d = cnt_q;
    if (accept && (in_i.operation == rtmm_pkg::OP_ROW)) begin
      if (in_i.row_end) begin
        cnt_d = '0;
      end else if (mac_en) begin
        cnt_d = cnt_q + rtmm_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== hw/rtl/rtmm_queue.sv =====
module rtmm_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rtmm_pkg::rtmm_cmd_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output rtmm_pkg::rtmm_cmd_t data_o,
  output logic                empty_o
);

  rtmm_pkg::rtmm_cmd_t         mem_q [rtmm_pkg::QDEPTH];
  logic [rtmm_pkg::QPTR_W-1:0] wptr_q, rptr_q;
  logic [rtmm_pkg::QPTR_W:0]   cnt_q;

  assign full_o  = (int'(cnt_q) == rtmm_pkg::QDEPTH);
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + rtmm_pkg::QPTR_W'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + rtmm_pkg::QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (rtmm_pkg::QPTR_W + 1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (rtmm_pkg::QPTR_W + 1)'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/rtmm_back.sv =====
module rtmm_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rtmm_pkg::rtmm_cmd_t head_i,
  input  logic                empty_i,
  output logic                pop_o,
  rtmm_out_if.source          out_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MAC   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]                 state_q, state_d;
  rtmm_pkg::rtmm_cmd_t        cmd_q, cmd_d;
  logic [rtmm_pkg::CNT_W-1:0] col_q, col_d;

  // MAC pipeline
  logic                       rd_vld_q, rd_vld_d;
  logic [rtmm_pkg::COL_W-1:0] col1_q, col2_q;
  logic                       mul_vld_q;
  logic signed [rtmm_pkg::PRD_W-1:0] prod_q;
  logic signed [rtmm_pkg::ACC_W-1:0] acc_q [rtmm_pkg::DIM_LIM];

  // B store
  logic                          ram_we;
  logic [rtmm_pkg::B_AW-1:0]     ram_raddr;
  logic [rtmm_pkg::VAL_W-1:0]    ram_rdata;

  // Output register
  logic                              out_vld_q, out_vld_d;
  logic [3:0]                        out_col_q;
  logic signed [rtmm_pkg::ACC_W-1:0] out_value_q;
  logic [rtmm_pkg::TAG_W-1:0]        out_tag_q;
  logic                              out_last_q;
  logic                              emit_ld;
  logic                              emit_last;
  logic                              col_last;

  assign col_last  = (col_q == cmd_q.ncol - rtmm_pkg::CNT_W'(1));
  assign emit_ld   = (state_q == ST_EMIT) && (!out_vld_q || out_o.ready);
  assign emit_last = emit_ld && col_last;
  assign ram_we    = pop_o && head_i.is_load;
  assign ram_raddr = {rtmm_pkg::IDX_W'(cmd_q.k), rtmm_pkg::IDX_W'(col_q)};

  rtmm_ram #(
    .WIDTH (rtmm_pkg::VAL_W),
    .DEPTH (rtmm_pkg::B_DEPTH)
  ) u_bstore (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (head_i.waddr),
    .wdata_i (head_i.value),
    .re_i    (rd_vld_d),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequence one command
  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    col_d    = col_q;
    pop_o    = 1'b0;
    rd_vld_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          cmd_d = head_i;
          col_d = '0;
          if (!head_i.is_load) begin
            if (head_i.mac_en) begin
              state_d = ST_MAC;
            end else if (head_i.row_end) begin
              state_d = ST_EMIT;
            end
          end
        end
      end
      ST_MAC: begin
        rd_vld_d = 1'b1;
        col_d    = col_q + rtmm_pkg::CNT_W'(1);
        if (col_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_q && !mul_vld_q) begin
          col_d   = '0;
          state_d = cmd_q.row_end ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (emit_ld) begin
          col_d = col_q + rtmm_pkg::CNT_W'(1);
          if (col_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (emit_ld) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      col_q     <= '0;
      rd_vld_q  <= 1'b0;
      mul_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      col_q     <= col_d;
      rd_vld_q  <= rd_vld_d;
      mul_vld_q <= rd_vld_q;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers: command, multiply stage, output
  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    col1_q <= col_q[rtmm_pkg::COL_W-1:0];
    col2_q <= col1_q;
    prod_q <= $signed(cmd_q.value) * $signed(ram_rdata);
    if (emit_ld) begin
      out_col_q   <= 4'(col_q);
      out_value_q <= acc_q[col_q[rtmm_pkg::COL_W-1:0]];
      out_tag_q   <= cmd_q.tag;
      out_last_q  <= col_last;
    end
  end

  // Accumulate, and clear every column after the last result of a row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rtmm_pkg::DIM_LIM; i++) begin
        acc_q[i] <= '0;
      end
    end else if (emit_last) begin
      for (int i = 0; i < rtmm_pkg::DIM_LIM; i++) begin
        acc_q[i] <= '0;
      end
    end else if (mul_vld_q) begin
      acc_q[col2_q] <= acc_q[col2_q] + rtmm_pkg::ACC_W'(prod_q);
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.out_col     = out_col_q;
  assign out_o.out_value   = out_value_q;
  assign out_o.out_row_tag = out_tag_q;
  assign out_o.last_of_row = out_last_q;

  // Emitting must wait for the MAC pipeline to drain
  a_emit_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (!rd_vld_q && !mul_vld_q))
    else $error("emit started with MAC pipeline busy");

  // Column counter stays inside the command's column range while issuing
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAC) |-> (col_q < cmd_q.ncol))
    else $error("column index past ncol");

  // Never pop an empty queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !empty_i)
    else $error("pop from empty queue");

  // Accumulator 0 is zero after the last result of a row, which is then valid and marked last
  a_acc_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_last |=> (acc_q[0] == '0) && out_o.valid && out_o.last_of_row)
    else $error("accumulators not cleared at row end");

endmodule

// ===== hw/rtl/row_times_matrix_mac_unit.sv =====
// Load transaction: writes the B store at the edge it leaves the command queue.
// Row element: the back end pops it and, within kdim, issues ncol RAM reads, then lets the multiply/add stages drain.
// Row end: after any drain the results follow in column order, one a cycle while the output is not stalled.
// The 4-entry command queue takes input, until it is full, while the back end or the output register stalls.
// Reset clears control, the accumulators and the element counter, and sets both registers
// to 16; the B store is not cleared and holds no valid data until written.
module row_times_matrix_mac_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  rtmm_in_if.sink                      in_i,
  rtmm_out_if.source                   out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rtmm_pkg::PADDR_W-1:0] paddr,
  input  logic [rtmm_pkg::PDATA_W-1:0] pwdata,
  output logic [rtmm_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  logic [rtmm_pkg::REG_W-1:0] inner_q, outc_q;
  logic                       cfg_we;
  rtmm_pkg::rtmm_cfg_t        cfg;
  logic                       push, pop, q_full, q_empty;
  rtmm_pkg::rtmm_cmd_t        cmd_in, cmd_head;

  // Register file
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_q <= rtmm_pkg::REG_W'(16);
      outc_q  <= rtmm_pkg::REG_W'(16);
    end else if (cfg_we) begin
      unique case (paddr[2])
        rtmm_pkg::REG_INNER_DIM: inner_q <= pwdata[rtmm_pkg::REG_W-1:0];
        rtmm_pkg::REG_OUT_COLS:  outc_q  <= pwdata[rtmm_pkg::REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      rtmm_pkg::REG_INNER_DIM: prdata = rtmm_pkg::PDATA_W'(inner_q);
      rtmm_pkg::REG_OUT_COLS:  prdata = rtmm_pkg::PDATA_W'(outc_q);
      default:                 prdata = '0;
    endcase
  end

  // Effective dimensions
  assign cfg.kdim = rtmm_pkg::clamp_dim(inner_q);
  assign cfg.ncol = rtmm_pkg::clamp_dim(outc_q);

  rtmm_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cfg_i    (cfg),
    .q_full_i (q_full),
    .push_o   (push),
    .cmd_o    (cmd_in)
  );

  rtmm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .data_o  (cmd_head),
    .empty_o (q_empty)
  );

  rtmm_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (cmd_head),
    .empty_i (q_empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
